// ===== sv/pid_pkg.sv =====
// Shared widths, register and flag codes, unit request structs and the
// saturating helpers for the PID controller. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pid_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int ACC_WIDTH = 48;
  localparam int PER_W     = DATA_W - 1;
  localparam int ERR_W     = DATA_W + 1;
  localparam int MAG_W     = ACC_WIDTH + DATA_W;
  localparam int DIV_N     = ACC_WIDTH + FRAC_BITS;
  localparam int DVS_W     = DATA_W + 1;
  localparam int MUL_CNT_W = $clog2(DATA_W);
  localparam int DIV_CNT_W = $clog2(DIV_N);
  localparam int CFG_IDX_W = 3;

  typedef logic signed [ACC_WIDTH-1:0] acc_t;
  typedef logic [MAG_W-1:0]            mag_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
  typedef logic [1:0]                  limit_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam mag_t ACC_CAP = mag_t'(1) << (ACC_WIDTH - 1);

  localparam cfg_idx_t REG_SETPOINT = cfg_idx_t'(0);
  localparam cfg_idx_t REG_PROP     = cfg_idx_t'(1);
  localparam cfg_idx_t REG_INTEG    = cfg_idx_t'(2);
  localparam cfg_idx_t REG_DERIV    = cfg_idx_t'(3);
  localparam cfg_idx_t REG_PERIOD   = cfg_idx_t'(4);
  localparam cfg_idx_t REG_OUT_MIN  = cfg_idx_t'(5);
  localparam cfg_idx_t REG_OUT_MAX  = cfg_idx_t'(6);

  localparam limit_t LIM_NONE = 2'd0;
  localparam limit_t LIM_MAX  = 2'd1;
  localparam limit_t LIM_MIN  = 2'd2;

  typedef struct packed {
    logic                 start;
    logic [DATA_W-1:0]    a;
    logic [ACC_WIDTH-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  function automatic logic [DATA_W-1:0] mag_data(input logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [ERR_W-1:0] mag_err(input logic [ERR_W-1:0] x);
    return x[ERR_W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [ACC_WIDTH-1:0] mag_acc(input logic [ACC_WIDTH-1:0] x);
    return x[ACC_WIDTH-1] ? (~x + 1'b1) : x;
  endfunction

  // Apply sign to a magnitude, saturating to the accumulator range.
  function automatic acc_t sat_mag(input mag_t m, input logic neg);
    logic [ACC_WIDTH-1:0] low;
    low = m[ACC_WIDTH-1:0];
    if (m >= ACC_CAP) begin
      return neg ? ACC_MIN : ACC_MAX;
    end
    return neg ? acc_t'(~low + 1'b1) : acc_t'(low);
  endfunction

  function automatic acc_t sat_add(input acc_t a, input acc_t b);
    logic [ACC_WIDTH:0] s;
    s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end
    return acc_t'(s[ACC_WIDTH-1:0]);
  endfunction

  function automatic acc_t sat_sub(input acc_t a, input acc_t b);
    logic [ACC_WIDTH:0] s;
    s = {a[ACC_WIDTH-1], a} - {b[ACC_WIDTH-1], b};
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end
    return acc_t'(s[ACC_WIDTH-1:0]);
  endfunction

endpackage

`default_nettype wire

// ===== sv/pid_ser_mul.sv =====
// Radix-2 shift-add multiplier for unsigned magnitudes, one multiplier bit
// per cycle. Depends on pid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pid_ser_mul (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pid_pkg::mul_req_t req,
  output logic                  busy,
  output pid_pkg::mag_t         prod
);

  logic                              busy_r, busy_nxt;
  logic [pid_pkg::MUL_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [pid_pkg::ACC_WIDTH-1:0]     b_r, b_nxt;
  pid_pkg::mag_t                     p_r, p_nxt;
  logic [pid_pkg::ACC_WIDTH:0]       sum;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    sum = {1'b0, p_r[pid_pkg::MAG_W-1:pid_pkg::DATA_W]} +
          (p_r[0] ? {1'b0, b_r} : '0);
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      b_nxt    = req.b;
      p_nxt    = {{pid_pkg::ACC_WIDTH{1'b0}}, req.a};
    end else if (busy_r) begin
      // add the partial product, retire one multiplier bit
      p_nxt   = {sum, p_r[pid_pkg::DATA_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pid_pkg::MUL_CNT_W'(pid_pkg::DATA_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign busy = busy_r;
  assign prod = p_r;

`ifndef ASSERT_OFF
  a_mul_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("multiplier restarted while busy");
`endif

endmodule

`default_nettype wire

// ===== sv/pid_ser_div.sv =====
// Restoring divider, one quotient bit per cycle, with a sticky overflow
// flag that pins the quotient at the accumulator cap. Depends on pid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pid_ser_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pid_pkg::div_req_t req,
  output logic                  busy,
  output pid_pkg::mag_t         quot
);

  logic                              busy_r, busy_nxt;
  logic [pid_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [pid_pkg::DIV_N-1:0]         n_r, n_nxt;
  logic [pid_pkg::DVS_W-1:0]         d_r, d_nxt;
  logic [pid_pkg::DVS_W-1:0]         rem_r, rem_nxt;
  logic [pid_pkg::ACC_WIDTH-1:0]     q_r, q_nxt;
  logic                              ovf_r, ovf_nxt;
  logic [pid_pkg::DVS_W:0]           r2;
  logic [pid_pkg::DVS_W:0]           r2_sub;
  logic                              ge;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    r2       = {rem_r, n_r[pid_pkg::DIV_N-1]};
    r2_sub   = r2 - {1'b0, d_r};
    ge       = (r2 >= {1'b0, d_r});
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      n_nxt    = req.dividend;
      d_nxt    = req.divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      n_nxt   = {n_r[pid_pkg::DIV_N-2:0], 1'b0};
      rem_nxt = ge ? r2_sub[pid_pkg::DVS_W-1:0] : r2[pid_pkg::DVS_W-1:0];
      q_nxt   = {q_r[pid_pkg::ACC_WIDTH-2:0], ge};
      // a bit shifted out of the quotient means it is past the cap
      ovf_nxt = ovf_r | q_r[pid_pkg::ACC_WIDTH-1];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pid_pkg::DIV_CNT_W'(pid_pkg::DIV_N - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
  end

  assign busy = busy_r;
  assign quot = ovf_r ? pid_pkg::ACC_CAP : pid_pkg::mag_t'(q_r);

`ifndef ASSERT_OFF
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < d_r))
    else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== sv/pid_antiwindup_controller_top.sv =====
// Top level of the PID controller with back-calculation anti-windup.
// Depends on pid_pkg, pid_ser_mul and pid_ser_div.
`timescale 1ns / 1ps
`default_nettype none

// One measurement request in gives one clamped drive request out, in signed
// Q16.16. The block works on one sample at a time: a request is taken only
// while the sequencer is idle, and a result waiting in the output register
// does not block that. A sample's processing time is set by the 64-step
// restoring divider (derivative, then back-calculation term, the latter
// skipped when the integral gain is zero) and by the 32-step shift-add
// multiplier, which forms the four products, three of them while the
// divider runs (two when the integral gain is zero) and one after the
// integral update. Configuration writes are always taken (cfg_ready is tied
// high) and must only happen while no sample is in flight; an index past
// the last register is dropped. A zero sample period acts as one LSB. With
// crossed limits, a value above the upper one drives it, any other the lower.
module pid_antiwindup_controller_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pid_pkg::DATA_W-1:0]    in_measurement,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pid_pkg::DATA_W-1:0]         out_drive,
  output logic [1:0]                         out_limit_hit,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pid_pkg::DATA_W-1:0]    cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_A, S_A1, S_A2, S_B, S_B1, S_I1, S_I2,
    S_C, S_C1, S_U1, S_U2, S_CLAMP
  } state_t;

  state_t state_r;

  // configuration registers
  logic [pid_pkg::DATA_W-1:0] sp_r, kp_r, ki_r, kd_r, min_r, max_r;
  logic [pid_pkg::PER_W-1:0]  per_r;

  // controller state
  logic [pid_pkg::DATA_W-1:0] last_meas_r;
  logic [pid_pkg::DATA_W-1:0] last_clamp_r;
  pid_pkg::acc_t              integ_r;
  pid_pkg::acc_t              last_unc_r;

  // per-sample working registers
  logic [pid_pkg::DATA_W-1:0] meas_r;
  logic [pid_pkg::ERR_W-1:0]  err_r, ddiff_r;
  pid_pkg::acc_t              bd_r, delta_r, back_r, prop_r, deriv_r;
  pid_pkg::acc_t              dterm_r, iterm_r, u_r;

  // output register
  logic                       out_valid_r;
  logic [pid_pkg::DATA_W-1:0] out_drive_r;
  pid_pkg::limit_t            out_limit_r;

  logic [pid_pkg::PER_W-1:0]  per_eff;
  logic [pid_pkg::ERR_W-1:0]  err_nxt, ddiff_nxt;
  logic                       in_accept;
  logic                       out_free;
  logic                       ki_zero;

  pid_pkg::mul_req_t          mul_req;
  pid_pkg::div_req_t          div_req;
  logic                       mul_busy, div_busy;
  pid_pkg::mag_t              mul_prod, div_quot;

  pid_pkg::acc_t              hi_ext, lo_ext;
  logic [pid_pkg::DATA_W-1:0] drive_nxt;
  pid_pkg::limit_t            limit_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign ki_zero   = (ki_r == '0);

  // zero period runs as the smallest period
  assign per_eff = (per_r == '0) ? pid_pkg::PER_W'(1) : per_r;

  // both differences are exact in one extra bit
  assign err_nxt   = {sp_r[pid_pkg::DATA_W-1], sp_r} -
                     {in_measurement[pid_pkg::DATA_W-1], in_measurement};
  assign ddiff_nxt = {last_meas_r[pid_pkg::DATA_W-1], last_meas_r} -
                     {in_measurement[pid_pkg::DATA_W-1], in_measurement};

  // Issue unit requests: derivative division under the period and proportional
  // products, then the back-calculation division under the derivative product.
  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state_r)
      S_A: begin
        mul_req.start    = 1'b1;
        mul_req.a        = pid_pkg::DATA_W'(per_eff);
        mul_req.b        = pid_pkg::ACC_WIDTH'(pid_pkg::mag_err(err_r));
        div_req.start    = 1'b1;
        div_req.dividend = pid_pkg::DIV_N'(pid_pkg::mag_err(ddiff_r)) << pid_pkg::FRAC_BITS;
        div_req.divisor  = pid_pkg::DVS_W'(per_eff);
      end
      S_A1: begin
        mul_req.start = !mul_busy;
        mul_req.a     = pid_pkg::mag_data(kp_r);
        mul_req.b     = pid_pkg::ACC_WIDTH'(pid_pkg::mag_err(err_r));
      end
      S_B: begin
        mul_req.start    = 1'b1;
        mul_req.a        = pid_pkg::mag_data(kd_r);
        mul_req.b        = pid_pkg::mag_acc(deriv_r);
        // skip the back-calculation term for zero integral gain
        div_req.start    = !ki_zero;
        div_req.dividend = pid_pkg::DIV_N'(pid_pkg::mag_acc(bd_r)) << pid_pkg::FRAC_BITS;
        div_req.divisor  = {pid_pkg::mag_data(ki_r), 1'b0};
      end
      S_C: begin
        mul_req.start = 1'b1;
        mul_req.a     = pid_pkg::mag_data(ki_r);
        mul_req.b     = pid_pkg::mag_acc(integ_r);
      end
      default: begin
      end
    endcase
  end

  pid_ser_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  pid_ser_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // Clamp: test the upper limit first.
  always_comb begin
    hi_ext = pid_pkg::acc_t'($signed(max_r));
    lo_ext = pid_pkg::acc_t'($signed(min_r));
    if (u_r > hi_ext) begin
      drive_nxt = max_r;
      limit_nxt = pid_pkg::LIM_MAX;
    end else if (u_r < lo_ext) begin
      drive_nxt = min_r;
      limit_nxt = pid_pkg::LIM_MIN;
    end else begin
      drive_nxt = u_r[pid_pkg::DATA_W-1:0];
      limit_nxt = pid_pkg::LIM_NONE;
    end
  end

  // Sequencer, controller state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      last_meas_r  <= '0;
      last_clamp_r <= '0;
      integ_r      <= '0;
      last_unc_r   <= '0;
    end else begin
      // drop the result once the request is taken downstream, unless the
      // clamp step reloads the register in the same cycle
      if (out_valid_r && !out_stall && state_r != S_CLAMP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            state_r <= S_A;
          end
        end
        S_A: state_r <= S_A1;
        S_A1: begin
          if (!mul_busy) begin
            state_r <= S_A2;
          end
        end
        S_A2: begin
          if (!mul_busy && !div_busy) begin
            state_r <= S_B;
          end
        end
        S_B: state_r <= S_B1;
        S_B1: begin
          if (!mul_busy && !div_busy) begin
            state_r <= S_I1;
          end
        end
        S_I1: state_r <= S_I2;
        S_I2: begin
          integ_r <= pid_pkg::sat_add(integ_r, delta_r);
          state_r <= S_C;
        end
        S_C: state_r <= S_C1;
        S_C1: begin
          if (!mul_busy) begin
            state_r <= S_U1;
          end
        end
        S_U1: state_r <= S_U2;
        S_U2: state_r <= S_CLAMP;
        S_CLAMP: begin
          // hold until the output register has room
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_drive_r  <= drive_nxt;
            out_limit_r  <= limit_nxt;
            last_unc_r   <= u_r;
            last_clamp_r <= drive_nxt;
            last_meas_r  <= meas_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Working registers: capture unit results as each run finishes.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          meas_r  <= in_measurement;
          err_r   <= err_nxt;
          ddiff_r <= ddiff_nxt;
        end
      end
      S_A: begin
        bd_r <= pid_pkg::sat_sub(pid_pkg::acc_t'($signed(last_clamp_r)), last_unc_r);
      end
      S_A1: begin
        if (!mul_busy) begin
          // period times half the error
          delta_r <= pid_pkg::sat_mag(mul_prod >> (pid_pkg::FRAC_BITS + 1),
                                      err_r[pid_pkg::ERR_W-1]);
        end
      end
      S_A2: begin
        if (!mul_busy && !div_busy) begin
          prop_r  <= pid_pkg::sat_mag(mul_prod >> pid_pkg::FRAC_BITS,
                                      kp_r[pid_pkg::DATA_W-1] ^ err_r[pid_pkg::ERR_W-1]);
          deriv_r <= pid_pkg::sat_mag(div_quot, ddiff_r[pid_pkg::ERR_W-1]);
        end
      end
      S_B1: begin
        if (!mul_busy && !div_busy) begin
          dterm_r <= pid_pkg::sat_mag(mul_prod >> pid_pkg::FRAC_BITS,
                                      kd_r[pid_pkg::DATA_W-1] ^ deriv_r[pid_pkg::ACC_WIDTH-1]);
          back_r  <= ki_zero ? '0 :
                     pid_pkg::sat_mag(div_quot,
                                      bd_r[pid_pkg::ACC_WIDTH-1] ^ ki_r[pid_pkg::DATA_W-1]);
        end
      end
      S_I1: delta_r <= pid_pkg::sat_add(delta_r, back_r);
      S_C1: begin
        if (!mul_busy) begin
          iterm_r <= pid_pkg::sat_mag(mul_prod >> pid_pkg::FRAC_BITS,
                                      ki_r[pid_pkg::DATA_W-1] ^ integ_r[pid_pkg::ACC_WIDTH-1]);
        end
      end
      S_U1: u_r <= pid_pkg::sat_add(prop_r, iterm_r);
      S_U2: u_r <= pid_pkg::sat_add(u_r, dterm_r);
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      kp_r  <= '0;
      ki_r  <= pid_pkg::DATA_W'(1) << pid_pkg::FRAC_BITS;
      kd_r  <= '0;
      per_r <= pid_pkg::PER_W'(1) << pid_pkg::FRAC_BITS;
      min_r <= {1'b1, {(pid_pkg::DATA_W-1){1'b0}}};
      max_r <= {1'b0, {(pid_pkg::DATA_W-1){1'b1}}};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pid_pkg::REG_SETPOINT: sp_r  <= cfg_data;
        pid_pkg::REG_PROP:     kp_r  <= cfg_data;
        pid_pkg::REG_INTEG:    ki_r  <= cfg_data;
        pid_pkg::REG_DERIV:    kd_r  <= cfg_data;
        pid_pkg::REG_PERIOD:   per_r <= cfg_data[pid_pkg::PER_W-1:0];
        pid_pkg::REG_OUT_MIN:  min_r <= cfg_data;
        pid_pkg::REG_OUT_MAX:  max_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_limit_hit = out_limit_r;

`ifndef ASSERT_OFF
  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!mul_busy && !div_busy))
    else $error("arithmetic unit still busy while sequencer is idle");

  a_result_from_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_CLAMP))
    else $error("result appeared outside the clamp step");

  a_clamp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLAMP && !out_stall) |=> out_valid_r)
    else $error("clamp step did not load the output register");
`endif

endmodule

`default_nettype wire

// ===== test/pid_ctrl_checker.sv =====
// Scoreboard for the PID controller: follows the sample, result and register
// channels, predicts each drive request and compares it. Depends on pid_pkg.
`timescale 1ns / 1ps

module pid_ctrl_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [pid_pkg::DATA_W-1:0]    in_measurement,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pid_pkg::DATA_W-1:0]    out_drive,
  input  logic [1:0]                    out_limit_hit,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pid_pkg::DATA_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            pending
);

  localparam int AW   = 48;
  localparam int FRAC = 16;

  typedef logic signed [AW-1:0]  accum_t;
  typedef logic signed [127:0]   wide_t;

  typedef struct packed {
    logic [pid_pkg::DATA_W-1:0] drive;
    pid_pkg::limit_t            limit;
  } drive_rec_t;

  localparam accum_t ACC_TOP    = {1'b0, {(AW-1){1'b1}}};
  localparam accum_t ACC_BOTTOM = {1'b1, {(AW-1){1'b0}}};
  localparam wide_t  WIDE_HI    = ACC_TOP;
  localparam wide_t  WIDE_LO    = ACC_BOTTOM;

  // Register copy
  logic signed [31:0] set_point, k_prop, k_integ, k_deriv, lim_lo, lim_hi;
  logic [30:0]        period;

  // Loop state
  logic signed [31:0] prev_meas, prev_drive;
  accum_t             integ, prev_raw;

  drive_rec_t due_drives[$];
  int         results_seen;

  function automatic accum_t clamp_wide(input wide_t v);
    if (v > WIDE_HI) return ACC_TOP;
    if (v < WIDE_LO) return ACC_BOTTOM;
    return v[AW-1:0];
  endfunction

  function automatic accum_t acc_sum(input accum_t a, input accum_t b);
    wide_t wa, wb;
    wa = a;
    wb = b;
    return clamp_wide(wa + wb);
  endfunction

  // Full product, shifted down on the magnitude, then signed and saturated.
  function automatic accum_t scaled_product(input wide_t a, input wide_t b, input int sh);
    logic [127:0] ma, mb, m;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    m   = (ma * mb) >> sh;
    return clamp_wide(neg ? -$signed(m) : $signed(m));
  endfunction

  function automatic accum_t scaled_quotient(input wide_t num, input wide_t den);
    logic [127:0] mn, md, m;
    logic         neg;
    neg = (num < 0) != (den < 0);
    mn  = (num < 0) ? -num : num;
    md  = (den < 0) ? -den : den;
    m   = (mn << FRAC) / md;
    return clamp_wide(neg ? -$signed(m) : $signed(m));
  endfunction

  // Advance the control loop by one sample and return the drive it gives.
  function automatic drive_rec_t advance_loop(input logic signed [31:0] meas);
    wide_t      per_w, err, ddiff, wa, wb;
    accum_t     deriv, delta, back, u;
    drive_rec_t r;
    per_w = (period == '0) ? 128'sd1 : 128'(period);
    wa    = set_point;
    wb    = meas;
    err   = wa - wb;
    wa    = prev_meas;
    ddiff = wa - wb;
    deriv = scaled_quotient(ddiff, per_w);
    delta = scaled_product(per_w, err, FRAC + 1);
    back  = '0;
    if (k_integ != 0) begin
      wa   = prev_drive;
      wb   = prev_raw;
      wa   = clamp_wide(wa - wb);
      wb   = k_integ;
      back = scaled_quotient(wa, wb * 2);
    end
    delta = acc_sum(delta, back);
    integ = acc_sum(integ, delta);
    u = acc_sum(scaled_product(k_prop, err, FRAC), scaled_product(k_integ, integ, FRAC));
    u = acc_sum(u, scaled_product(k_deriv, deriv, FRAC));
    // upper limit tested first, so with crossed limits only values above it win
    if (u > lim_hi) begin
      r.drive = lim_hi;
      r.limit = pid_pkg::LIM_MAX;
    end else if (u < lim_lo) begin
      r.drive = lim_lo;
      r.limit = pid_pkg::LIM_MIN;
    end else begin
      r.drive = u[31:0];
      r.limit = pid_pkg::LIM_NONE;
    end
    prev_raw   = u;
    prev_drive = r.drive;
    prev_meas  = meas;
    return r;
  endfunction

  always @(posedge clk) begin
    drive_rec_t want;
    if (!rst_n) begin
      set_point  = '0;
      k_prop     = '0;
      k_integ    = 32'sh0001_0000;
      k_deriv    = '0;
      period     = 31'h0001_0000;
      lim_lo     = 32'sh8000_0000;
      lim_hi     = 32'sh7fff_ffff;
      prev_meas  = '0;
      prev_drive = '0;
      integ      = '0;
      prev_raw   = '0;
      due_drives.delete();
      results_seen = 0;
      fail_count   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pid_pkg::REG_SETPOINT: set_point = cfg_data;
          pid_pkg::REG_PROP:     k_prop    = cfg_data;
          pid_pkg::REG_INTEG:    k_integ   = cfg_data;
          pid_pkg::REG_DERIV:    k_deriv   = cfg_data;
          pid_pkg::REG_PERIOD:   period    = cfg_data[30:0];
          pid_pkg::REG_OUT_MIN:  lim_lo    = cfg_data;
          pid_pkg::REG_OUT_MAX:  lim_hi    = cfg_data;
          default: ;
        endcase
      end
      // compare before queuing, so a result can never match its own sample
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_drives.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: unexpected drive %h limit %0d", results_seen,
                     out_drive, out_limit_hit);
        end else begin
          want = due_drives.pop_front();
          if (out_drive !== want.drive || out_limit_hit !== want.limit) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: expected drive %h limit %0d, got drive %h limit %0d",
                       results_seen, want.drive, want.limit, out_drive, out_limit_hit);
          end
        end
      end
      if (in_valid && !in_stall)
        due_drives.push_back(advance_loop(in_measurement));
    end
    pending = due_drives.size();
  end

endmodule

// ===== test/tb_pid_antiwindup_controller_top.sv =====
// Testbench top for the PID controller: clock, reset, register setup and
// sample stimulus with random stalls. Depends on pid_pkg, the checker, the DUT.
`timescale 1ns / 1ps

module tb_pid_antiwindup_controller_top;

  // Index past the last register: the block must drop it.
  localparam pid_pkg::cfg_idx_t REG_NONE = pid_pkg::cfg_idx_t'(7);

  localparam int WATCHDOG_LIMIT = 4000;   // idle cycles tolerated on all channels
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 200;    // a bit over one sample's latency
  localparam int RAND_BLOCKS    = 13;
  localparam int BLOCK_SAMPLES  = 100;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic [pid_pkg::DATA_W-1:0] in_measurement = '0;
  logic                       out_stall      = 1'b0;
  logic                       cfg_valid      = 1'b0;
  pid_pkg::cfg_idx_t          cfg_index      = '0;
  logic [pid_pkg::DATA_W-1:0] cfg_data       = '0;
  logic                       in_stall;
  logic                       out_valid;
  logic [pid_pkg::DATA_W-1:0] out_drive;
  logic [1:0]                 out_limit_hit;
  logic                       cfg_ready;

  int fail_count;
  int pending;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int samples_sent   = 0;
  int settings_count = 0;

  always #5 clk = ~clk;

  pid_antiwindup_controller_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_measurement (in_measurement),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive      (out_drive),
    .out_limit_hit  (out_limit_hit),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  pid_ctrl_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_measurement (in_measurement),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive      (out_drive),
    .out_limit_hit  (out_limit_hit),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Stall the result channel at the current rate; one update per falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watchdog: any accepted request on any channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("pid_antiwindup_controller_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one measurement request and hold it until accepted. Before it,
  // idle the sender one cycle at a time at the current rate. Valid is left
  // high on return; the next call either replaces the payload or drops valid.
  task automatic send_sample(input logic [pid_pkg::DATA_W-1:0] meas);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_measurement <= meas;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // Drop valid, then wait until every drive request has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_cfg(input pid_pkg::cfg_idx_t idx,
                          input logic [pid_pkg::DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Rewrite all registers once the block is idle. A stray write to the unused
  // index may ride along; the unused top bit of the period gets random data.
  task automatic load_settings(input logic [31:0] sp, input logic [31:0] kp,
                               input logic [31:0] ki, input logic [31:0] kd,
                               input logic [30:0] per, input logic [31:0] lo,
                               input logic [31:0] hi);
    wait_idle();
    if ($urandom_range(0, 1)) push_cfg(REG_NONE, $urandom());
    push_cfg(pid_pkg::REG_SETPOINT, sp);
    push_cfg(pid_pkg::REG_PROP, kp);
    push_cfg(pid_pkg::REG_INTEG, ki);
    push_cfg(pid_pkg::REG_DERIV, kd);
    push_cfg(pid_pkg::REG_PERIOD, {1'($urandom_range(0, 1)), per});
    push_cfg(pid_pkg::REG_OUT_MIN, lo);
    push_cfg(pid_pkg::REG_OUT_MAX, hi);
    settings_count++;
  endtask

  // Gains: mostly within +/-2.0, sometimes the extremes or anything at all.
  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3, 4:    return $urandom();
      default: return 32'($urandom_range(0, 32'h3ffff)) - 32'h2_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_period();
    case ($urandom_range(0, 9))
      0:       return 31'h0;
      1:       return 31'h7fff_ffff;
      2:       return 31'h1;
      default: return 31'($urandom_range(32'h100, 32'h2_0000));
    endcase
  endfunction

  task automatic rand_limits(output logic [31:0] lo, output logic [31:0] hi);
    case ($urandom_range(0, 7))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      1: begin
        // crossed limits
        lo = 32'($urandom_range(0, 32'h100_0000));
        hi = 32'h0 - 32'($urandom_range(0, 32'h100_0000));
      end
      2: begin
        lo = $urandom();
        hi = $urandom();
      end
      default: begin
        lo = 32'h0 - 32'($urandom_range(0, 32'h100_0000));
        hi = 32'($urandom_range(0, 32'h100_0000));
      end
    endcase
  endtask

  // Measurements sit around the setpoint plus a per-block bias, so the
  // integral winds up against the limits and has to unwind; some noise
  // and extremes are mixed in.
  function automatic logic [31:0] rand_measurement(input logic [31:0] sp,
                                                   input logic [31:0] bias);
    case ($urandom_range(0, 19))
      0:       return $urandom();
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      default: return sp + bias + 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
    endcase
  endfunction

  initial begin
    logic [31:0] sp, ki, lo, hi, bias;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, extremes of the measurement.
    send_sample(32'h0);
    send_sample(32'h7fff_ffff);
    send_sample(32'h8000_0000);
    send_sample(32'h1);
    send_sample(32'hffff_ffff);

    // Moderate gains and tight limits: swing into both limits and back.
    load_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0000_2000,
                  31'h0001_0000, 32'hff9c_0000, 32'h0064_0000);
    send_sample(32'h0);
    send_sample(32'h7fff_ffff);
    send_sample(32'h8000_0000);
    send_sample(32'h0001_0000);
    send_sample(32'h0001_0000);
    send_sample(32'hfff0_0000);

    // Zero integral gain, zero period, crossed limits.
    load_settings(32'hfffd_0000, 32'h0002_0000, 32'h0, 32'hffff_0000,
                  31'h0, 32'h000a_0000, 32'hfff6_0000);
    send_sample(32'h0005_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);
    send_sample(32'hffff_0000);
    send_sample(32'h0);

    // Extreme registers, both polarities; limits first pinned to zero, then wide open.
    load_settings(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                  31'h7fff_ffff, 32'h0, 32'h0);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);
    send_sample(32'h8000_0000);
    send_sample(32'h1);

    load_settings(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                  31'h1, 32'h8000_0000, 32'h7fff_ffff);
    send_sample(32'h7fff_ffff);
    send_sample(32'h8000_0000);
    send_sample(32'h0);

    // Random blocks: each with fresh settings and its own bias. Stall mix:
    // slow receiver first, then slow sender, then no stalls at all.
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      if (blk < 5) begin
        send_idle_pct = 11;
        recv_idle_pct = 58;
      end else if (blk < 10) begin
        send_idle_pct = 58;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      sp = ($urandom_range(0, 4) == 0) ? $urandom()
                                       : 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
      ki = ($urandom_range(0, 4) == 0) ? 32'h0 : rand_gain();
      rand_limits(lo, hi);
      load_settings(sp, rand_gain(), ki, rand_gain(), rand_period(), lo, hi);
      bias = 32'($urandom_range(0, 32'h40_0000)) - 32'h20_0000;
      for (int n = 0; n < BLOCK_SAMPLES; n++)
        send_sample(rand_measurement(sp, bias));
    end

    // Drain: wait for the last drive request, then a latency's worth more.
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d samples under %0d register settings plus reset defaults,",
             samples_sent, settings_count);
    $display("with stalls on the sample and drive channels in three mixes.");
    if (fail_count == 0 && pending == 0) begin
      $display("pid_antiwindup_controller_top: match");
    end else begin
      $display("pid_antiwindup_controller_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== pid_antiwindup_controller_top.f =====
sv/pid_pkg.sv
sv/pid_ser_mul.sv
sv/pid_ser_div.sv
sv/pid_antiwindup_controller_top.sv
test/pid_ctrl_checker.sv
test/tb_pid_antiwindup_controller_top.sv
